// ===== rtl/core/erb_pkg.sv =====
// Shared constants, types and codes of the epoch release buffer.
`default_nettype none
package erb_pkg;

  localparam int StoreDepth   = 32;
  localparam int StationBits  = 8;
  localparam int TimeBits     = 32;
  localparam int PayloadBits  = 64;
  localparam int WeekBits     = 12;
  localparam int SecQ4Bits    = 24;
  localparam int RoundSecBits = SecQ4Bits - 3;
  localparam int CfgBits      = 12;
  localparam int CfgIdxBits   = 2;
  localparam int KindBits     = 2;
  localparam int CntBits      = (StoreDepth > 2) ? $clog2(StoreDepth) : 1;
  localparam int ModCntBits   = $clog2(TimeBits);

  localparam logic [TimeBits-1:0] WeekSeconds = TimeBits'(604800);

  typedef enum logic [KindBits-1:0] {
    KIND_RELEASED = 2'd0,
    KIND_LATE     = 2'd1,
    KIND_FULL     = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_SAMPLING_RATE = 2'd0,
    REG_WAIT_SECONDS  = 2'd1,
    REG_REPORT_DROPS  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DECIDE,
    ST_FIND,
    ST_DIV,
    ST_EMIT,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [TimeBits-1:0]    etime;
    logic [StationBits-1:0] station;
    logic [PayloadBits-1:0] payload;
  } obs_t;

  typedef struct packed {
    logic valid;
    obs_t obs;
  } entry_t;

  typedef struct packed {
    kind_e                  kind;
    logic [StationBits-1:0] station;
    logic [TimeBits-1:0]    etime;
    logic [PayloadBits-1:0] payload;
    logic                   epoch_end;
    logic                   last;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/erb_ifs.sv =====
// Channel interfaces of the epoch release buffer: observations, results, configuration.
`default_nettype none
interface erb_obs_if import erb_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [StationBits-1:0] station;
  logic                   first_obs;
  logic [WeekBits-1:0]    gps_week;
  logic [SecQ4Bits-1:0]   week_seconds_q4;
  logic [PayloadBits-1:0] payload;
  modport source (output valid, station, first_obs, gps_week, week_seconds_q4, payload,
                  input ready);
  modport sink (input valid, station, first_obs, gps_week, week_seconds_q4, payload,
                output ready);
endinterface

interface erb_res_if import erb_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [KindBits-1:0]    kind;
  logic [StationBits-1:0] out_station;
  logic [TimeBits-1:0]    epoch_time;
  logic [PayloadBits-1:0] out_payload;
  logic                   epoch_end;
  logic                   last;
  modport source (output valid, kind, out_station, epoch_time, out_payload, epoch_end, last,
                  input ready);
  modport sink (input valid, kind, out_station, epoch_time, out_payload, epoch_end, last,
                output ready);
endinterface

interface erb_cfg_if import erb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CfgIdxBits-1:0] index;
  logic [CfgBits-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/erb_cell.sv =====
// One storage cell of the entry chain: shifts toward the tail on insert, toward the head on rotate.
`default_nettype none
module erb_cell import erb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cell_op_e op_i,
  input  entry_t   left_i,
  input  entry_t   right_i,
  input  logic     prefix_i,
  output entry_t   entry_o,
  output logic     prefix_o
);

  logic valid_q, valid_d;
  obs_t obs_q, obs_d;

  // An insert moves the cell only when every cell ahead of it is occupied,
  // so the first hole absorbs the shift.
  always_comb begin
    valid_d = valid_q;
    obs_d   = obs_q;
    case (op_i)
      CELL_INSERT: begin
        if (prefix_i) begin
          valid_d = left_i.valid;
          obs_d   = left_i.obs;
        end
      end
      CELL_ROTATE: begin
        valid_d = right_i.valid;
        obs_d   = right_i.obs;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obs_q <= obs_d;
  end

  assign entry_o  = '{valid: valid_q, obs: obs_q};
  assign prefix_o = prefix_i & valid_q;

endmodule
`default_nettype wire

// ===== rtl/core/erb_mod_unit.sv =====
// Bit-serial remainder unit that tests a second for divisibility by the sampling rate.
`default_nettype none
module erb_mod_unit import erb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [TimeBits-1:0] dividend_i,
  input  logic [CfgBits-1:0]  divisor_i,
  output logic                busy_o,
  output logic                zero_o
);

  logic                  busy_q, busy_d;
  logic [ModCntBits-1:0] cnt_q, cnt_d;
  logic [TimeBits-1:0]   dvd_q, dvd_d;
  logic [CfgBits-1:0]    div_q, div_d;
  logic [CfgBits-1:0]    rem_q, rem_d;
  logic [CfgBits:0]      trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[TimeBits-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // Restoring step: the remainder stays below the divisor.
      if (trial >= {1'b0, div_q}) begin
        rem_d = CfgBits'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[CfgBits-1:0];
      end
      dvd_d = {dvd_q[TimeBits-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ModCntBits'(TimeBits - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign zero_o = (rem_q == '0);

endmodule
`default_nettype wire

// ===== rtl/core/epoch_release_buffer.sv =====
// Top level of the epoch release buffer: control sequencer around the entry chain.
`default_nettype none
// Observations enter on obs_i, one transfer per observation; results leave on
// res_o, and the three settings are written on cfg_i, which is always ready.
// Write the settings only while no observation is in flight.
// An observation that is dropped without a result passes ST_CALC and ST_DECIDE
// and returns to ST_IDLE; one that is stored or answered by a drop result
// without a release passes ST_CALC, ST_DECIDE and ST_FLUSH, where it can stall.
// When it releases seconds, the entry chain makes one full rotation to find
// the oldest second in the window, and then for each released second the
// remainder unit runs (skipped when the sampling rate is zero) and the chain
// makes one more rotation that removes that second's entries, emitting them
// only when the rate divides the second or is zero, while finding the next one.
// obs_i is ready again once the last result of the item has entered
// the output register.
// Results are held in a one-deep pending stage, so that epoch_end and last can
// be set, and then in the output register; a stalled receiver holds the chain
// in place and nothing is lost. Reset empties the store, clears the release
// mark, and sets the sampling rate to 0, the wait to 1 s and drop reporting on.
module epoch_release_buffer import erb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  erb_obs_if.sink   obs_i,
  erb_res_if.source res_o,
  erb_cfg_if.sink   cfg_i
);

  localparam logic [CntBits-1:0] CntLast = CntBits'(StoreDepth - 1);

  state_e state_q, state_d;
  logic [CntBits-1:0]      cnt_q, cnt_d;
  logic [CfgBits-1:0]      rate_q, wait_q;
  logic                    report_q;
  logic [TimeBits-1:0]     mark_q, mark_d;
  logic [TimeBits-1:0]     lo_q, lo_d, limit_q, limit_d;
  logic [TimeBits-1:0]     cur_q, cur_d, best_q, best_d;
  logic                    found_q, found_d, emit_q, emit_d;
  logic [StationBits-1:0]  station_q, station_d;
  logic                    first_q, first_d;
  logic [PayloadBits-1:0]  payload_q, payload_d;
  logic [TimeBits-1:0]     prod_q, prod_d, time_q, time_d;
  logic [RoundSecBits-1:0] rsec_q, rsec_d;
  logic                    pend_valid_q, pend_valid_d, out_valid_q, out_valid_d;
  result_t                 pend_q, pend_d, out_q, out_d;

  // Chain wiring.
  cell_op_e cell_op;
  logic     kill;
  entry_t   entries [StoreDepth];
  entry_t   lefts   [StoreDepth];
  entry_t   rights  [StoreDepth];
  logic     prefix  [StoreDepth+1];
  entry_t   new_entry, wrap_entry, head;
  logic     full;

  logic                mod_start, mod_busy, mod_zero;
  logic [TimeBits-1:0] mod_dividend;

  // Datapath helpers.
  logic [TimeBits-1:0] wait_eff, mark_eff, best_now;
  logic                found_now, cand, match, stall, out_free, push;
  result_t             push_res;

  assign head       = entries[0];
  assign new_entry  = '{valid: 1'b1, obs: '{etime: time_q, station: station_q,
                                            payload: payload_q}};
  assign wrap_entry = '{valid: head.valid & ~kill, obs: head.obs};
  assign prefix[0]  = 1'b1;
  assign full       = prefix[StoreDepth];

  always_comb begin
    lefts[0]              = new_entry;
    rights[StoreDepth-1]  = wrap_entry;
    for (int i = 1; i < StoreDepth; i++) begin
      lefts[i]    = entries[i-1];
      rights[i-1] = entries[i];
    end
  end

  for (genvar g = 0; g < StoreDepth; g++) begin : g_cell
    erb_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .op_i     (cell_op),
      .left_i   (lefts[g]),
      .right_i  (rights[g]),
      .prefix_i (prefix[g]),
      .entry_o  (entries[g]),
      .prefix_o (prefix[g+1])
    );
  end

  erb_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dividend),
    .divisor_i  (rate_q),
    .busy_o     (mod_busy),
    .zero_o     (mod_zero)
  );

  // Configuration writes are taken in any cycle.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= '0;
      wait_q   <= CfgBits'(1);
      report_q <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_SAMPLING_RATE: rate_q   <= cfg_i.data;
        REG_WAIT_SECONDS:  wait_q   <= cfg_i.data;
        REG_REPORT_DROPS:  report_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign wait_eff    = (wait_q == '0) ? TimeBits'(1) : TimeBits'(wait_q);
  assign mark_eff    = (mark_q == '0) ? time_q - 1'b1 : mark_q;
  assign out_free    = ~out_valid_q | res_o.ready;
  assign obs_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    mark_d       = mark_q;
    lo_d         = lo_q;
    limit_d      = limit_q;
    cur_d        = cur_q;
    best_d       = best_q;
    found_d      = found_q;
    emit_d       = emit_q;
    station_d    = station_q;
    first_d      = first_q;
    payload_d    = payload_q;
    prod_d       = prod_q;
    rsec_d       = rsec_q;
    time_d       = time_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    cell_op      = CELL_HOLD;
    kill         = 1'b0;
    mod_start    = 1'b0;
    mod_dividend = best_q;
    push         = 1'b0;
    push_res     = pend_q;
    cand         = 1'b0;
    match        = 1'b0;
    stall        = 1'b0;
    found_now    = found_q;
    best_now     = best_q;

    case (state_q)
      ST_IDLE: begin
        if (obs_i.valid) begin
          station_d = obs_i.station;
          first_d   = obs_i.first_obs;
          payload_d = obs_i.payload;
          prod_d    = TimeBits'({{(TimeBits-WeekBits){1'b0}}, obs_i.gps_week} * WeekSeconds);
          rsec_d    = RoundSecBits'(({1'b0, obs_i.week_seconds_q4} + (SecQ4Bits+1)'(8)) >> 4);
          state_d   = ST_CALC;
        end
      end

      ST_CALC: begin
        time_d  = prod_q + TimeBits'(rsec_q);
        state_d = ST_DECIDE;
      end

      ST_DECIDE: begin
        mark_d = mark_eff;
        if (time_q <= mark_eff) begin
          if (first_q && report_q) begin
            pend_valid_d = 1'b1;
            pend_d       = '{kind: KIND_LATE, station: station_q, etime: time_q,
                             payload: payload_q, epoch_end: 1'b0, last: 1'b0};
            state_d      = ST_FLUSH;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          if (full) begin
            pend_valid_d = 1'b1;
            pend_d       = '{kind: KIND_FULL, station: station_q, etime: time_q,
                             payload: payload_q, epoch_end: 1'b0, last: 1'b0};
          end else begin
            cell_op = CELL_INSERT;
          end
          if ({1'b0, time_q} > ({1'b0, mark_eff} + {1'b0, wait_eff})) begin
            limit_d = time_q - wait_eff;
            mark_d  = time_q - wait_eff;
            lo_d    = mark_eff;
            cnt_d   = '0;
            found_d = 1'b0;
            state_d = ST_FIND;
          end else begin
            state_d = ST_FLUSH;
          end
        end
      end

      ST_FIND: begin
        // One rotation finds the oldest second inside the window.
        cell_op = CELL_ROTATE;
        cand = head.valid && (head.obs.etime > lo_q) && (head.obs.etime <= limit_q);
        if (cand && (!found_q || head.obs.etime < best_q)) begin
          found_now = 1'b1;
          best_now  = head.obs.etime;
        end
        found_d = found_now;
        best_d  = best_now;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          cnt_d   = '0;
          found_d = 1'b0;
          if (found_now) begin
            cur_d        = best_now;
            mod_dividend = best_now;
            if (rate_q == '0) begin
              emit_d  = 1'b1;
              state_d = ST_EMIT;
            end else begin
              mod_start = 1'b1;
              state_d   = ST_DIV;
            end
          end else begin
            state_d = ST_FLUSH;
          end
        end
      end

      ST_DIV: begin
        if (!mod_busy) begin
          emit_d  = mod_zero;
          cnt_d   = '0;
          found_d = 1'b0;
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        // Newest-first rotation: entries of the current second leave the
        // chain, and the next second in the window is found on the way.
        match = head.valid && (head.obs.etime == cur_q);
        stall = match && emit_q && pend_valid_q && !out_free;
        if (!stall) begin
          cell_op = CELL_ROTATE;
          kill    = match;
          if (match && emit_q) begin
            if (pend_valid_q) begin
              push               = 1'b1;
              push_res.epoch_end = pend_q.epoch_end && (pend_q.etime != cur_q);
              push_res.last      = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_d       = '{kind: KIND_RELEASED, station: head.obs.station, etime: cur_q,
                             payload: head.obs.payload, epoch_end: 1'b1, last: 1'b0};
          end
          cand = head.valid && (head.obs.etime > cur_q) && (head.obs.etime <= limit_q);
          if (cand && (!found_q || head.obs.etime < best_q)) begin
            found_now = 1'b1;
            best_now  = head.obs.etime;
          end
          found_d = found_now;
          best_d  = best_now;
          cnt_d   = cnt_q + 1'b1;
          if (cnt_q == CntLast) begin
            cnt_d   = '0;
            found_d = 1'b0;
            if (found_now) begin
              cur_d        = best_now;
              mod_dividend = best_now;
              if (rate_q == '0) begin
                emit_d  = 1'b1;
                state_d = ST_EMIT;
              end else begin
                mod_start = 1'b1;
                state_d   = ST_DIV;
              end
            end else begin
              state_d = ST_FLUSH;
            end
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          push          = 1'b1;
          push_res.last = 1'b1;
          pend_valid_d  = 1'b0;
          state_d       = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_d       = push_res;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      mark_q       <= '0;
      found_q      <= 1'b0;
      emit_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      mark_q       <= mark_d;
      found_q      <= found_d;
      emit_q       <= emit_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    limit_q   <= limit_d;
    cur_q     <= cur_d;
    best_q    <= best_d;
    station_q <= station_d;
    first_q   <= first_d;
    payload_q <= payload_d;
    prod_q    <= prod_d;
    rsec_q    <= rsec_d;
    time_q    <= time_d;
    pend_q    <= pend_d;
    out_q     <= out_d;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.kind        = out_q.kind;
  assign res_o.out_station = out_q.station;
  assign res_o.epoch_time  = out_q.etime;
  assign res_o.out_payload = out_q.payload;
  assign res_o.epoch_end   = out_q.epoch_end;
  assign res_o.last        = out_q.last;

endmodule
`default_nettype wire

// ===== rtl/core/erb_checker.sv =====
// Port-level checks of the epoch release buffer, bound to the top level.
`default_nettype none
module erb_checker import erb_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [KindBits-1:0] out_kind,
  input wire logic                out_epoch_end,
  input wire logic                out_last
);

  // A result waiting for the receiver stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // An observation is worked on alone: no second transfer right behind it.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  // Drop results never close a second.
  a_drop_no_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_kind != KIND_RELEASED) |-> !out_epoch_end)
    else $error("epoch_end set on a drop result");

  // A late drop is always the only result of its observation.
  a_late_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_kind == KIND_LATE) |-> out_last)
    else $error("late drop not marked last");

endmodule

bind epoch_release_buffer erb_checker u_erb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (obs_i.valid),
  .in_ready      (obs_i.ready),
  .out_valid     (res_o.valid),
  .out_ready     (res_o.ready),
  .out_kind      (res_o.kind),
  .out_epoch_end (res_o.epoch_end),
  .out_last      (res_o.last)
);
`default_nettype wire
